/* hdl/pmst_pkg.sv */
// Shared types and constants for the Prim spanning-tree block.
// Holds the input and result word layouts and the controller/datapath
// command and status structs. No dependencies.
package pmst_pkg;

  // Command field codes of an input word
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  // Width of the vertex_count register
  localparam int CFG_BITS = 6;

  // Reset value of vertex_count
  localparam logic [CFG_BITS-1:0] VCOUNT_RESET = 6'd32;

  // Input word: write an edge, or start a tree run
  typedef struct packed {
    logic        command;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [15:0] weight;
  } in_word_t;

  // Result word: one tree edge per reported vertex
  typedef struct packed {
    logic [4:0]  vertex;
    logic [4:0]  parent_vertex;
    logic [15:0] edge_weight;
    logic        reachable;
    logic        last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_step;   // write zero at the clear pointer and advance it
    logic write;      // store an edge weight from the input word
    logic run_init;   // load keys, clear tree flags, latch vertex count
    logic pick;       // take the best candidate, or set up the report
    logic scan_step;  // issue one matrix read of the relax pass
    logic emit_step;  // issue one report read
  } pmst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;   // clear pointer at the last entry
    logic found;      // a candidate vertex is waiting to join the tree
    logic cnt_last;   // scan counter at vertex count minus one
  } pmst_stat_t;

endpackage

/* hdl/pmst_ctrl.sv */
// Controller state machine of the Prim spanning-tree block.
// Sequences the clearing pass, edge writes, relax passes and the report.
// Depends on pmst_pkg.
module pmst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_command,
  input  pmst_pkg::pmst_stat_t stat,
  output pmst_pkg::pmst_cmd_t  cmd,
  output logic                busy
);
  import pmst_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_RELAX = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_command == CMD_RUN) begin
            cmd.run_init = 1'b1;
            state_nxt    = S_PICK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = stat.found ? S_RELAX : S_EMIT;
      end
      S_RELAX: begin
        cmd.scan_step = 1'b1;
        if (stat.cnt_last) state_nxt = S_TAIL;
      end
      // last matrix word of the pass is folded in here
      S_TAIL: begin
        state_nxt = S_PICK;
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (stat.cnt_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* hdl/pmst_dpath.sv */
// Datapath of the Prim spanning-tree block: weight matrix memory,
// per-vertex keys, tree flags and parents, scan counters, result register.
// Depends on pmst_pkg.
module pmst_dpath #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmst_pkg::in_word_t            in_word,
  input  logic                          cfg_wr_en,
  input  logic [pmst_pkg::CFG_BITS-1:0] cfg_wr_data,
  input  pmst_pkg::pmst_cmd_t           cmd,
  output pmst_pkg::pmst_stat_t          stat,
  output logic                          out_valid,
  output pmst_pkg::out_word_t           out_word
);
  import pmst_pkg::*;

  localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = WEIGHT_BITS + 1;
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [6:0]    MAX7    = 7'(MAX_VERTICES);

  // Configuration and run length
  logic [CFG_BITS-1:0] vcount_r;
  logic [6:0]          vc7;
  logic [6:0]          n7;
  logic [VW-1:0]       last_idx_r;

  // Weight matrix, one cell per unordered vertex pair
  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic [WEIGHT_BITS-1:0] rd_data_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [WEIGHT_BITS-1:0] mem_wd;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          clr_cnt_r;

  // Edge write decode
  logic [6:0]             row7;
  logic [6:0]             col7;
  logic [VW-1:0]          wr_ri;
  logic [VW-1:0]          wr_ci;
  logic                   wr_ok;
  logic [WEIGHT_BITS-1:0] wr_w;

  // Per-vertex state
  logic [KW-1:0]           key_r    [MAX_VERTICES];
  logic [VW-1:0]           parent_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] in_tree_r;

  // Scan state
  logic [VW-1:0] cnt_r;
  logic [VW-1:0] pick_r;
  logic [VW-1:0] d_idx_r;
  logic          rx_valid_r;
  logic          em_valid_r;
  logic          found_r;
  logic [VW-1:0] best_r;
  logic [KW-1:0] best_key_r;

  // Relax and candidate logic
  logic [KW-1:0] kd;
  logic          td;
  logic [KW-1:0] wd_ext;
  logic          relax;
  logic [KW-1:0] newk;
  logic          cand;

  // Result register
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t res;

  // Vertex count clamped to the supported range
  always_comb begin
    vc7 = 7'(vcount_r);
    if (vc7 < 7'd2) begin
      n7 = 7'd2;
    end else if (vc7 > MAX7) begin
      n7 = MAX7;
    end else begin
      n7 = vc7;
    end
  end

  // Edge write: range check, row and column index, weight width
  always_comb begin
    row7  = 7'(in_word.row);
    col7  = 7'(in_word.col);
    wr_ri = row7[VW-1:0];
    wr_ci = col7[VW-1:0];
    wr_ok = (row7 < MAX7) && (col7 < MAX7);
    wr_w  = WEIGHT_BITS'(in_word.weight);
  end

  // Memory port selection: clear sweep or edge write; read at (pick, cnt)
  always_comb begin
    mem_we = cmd.clr_step || (cmd.write && wr_ok);
    if (cmd.clr_step) begin
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_wa = (wr_ri < wr_ci) ? {wr_ri, wr_ci} : {wr_ci, wr_ri};
      mem_wd = wr_w;
    end
    rd_addr = (pick_r < cnt_r) ? {pick_r, cnt_r} : {cnt_r, pick_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) wmem[mem_wa] <= mem_wd;
    rd_data_r <= wmem[rd_addr];
  end

  // Relax the vertex whose matrix word just arrived, track the best key
  always_comb begin
    kd     = key_r[d_idx_r];
    td     = in_tree_r[d_idx_r];
    wd_ext = {1'b0, rd_data_r};
    relax  = rx_valid_r && (rd_data_r != '0) && !td && (wd_ext < kd);
    newk   = relax ? wd_ext : kd;
    cand   = rx_valid_r && !td && !newk[KW-1] && (!found_r || (newk < best_key_r));
  end

  // Keys and parents
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        key_r[i]    <= (i == 0) ? '0 : KEY_INF;
        parent_r[i] <= '0;
      end
    end else if (relax) begin
      key_r[d_idx_r]    <= newk;
      parent_r[d_idx_r] <= pick_r;
    end
  end

  // Result fields of the vertex read last cycle
  always_comb begin
    res.vertex        = 5'(d_idx_r);
    res.reachable     = td;
    res.parent_vertex = td ? 5'(parent_r[d_idx_r]) : 5'd0;
    res.edge_weight   = td ? 16'(kd[WEIGHT_BITS-1:0]) : 16'd0;
    res.last          = (d_idx_r == last_idx_r);
  end

  always_ff @(posedge clk) begin
    if (em_valid_r) out_word_r <= res;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= VCOUNT_RESET;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      pick_r      <= '0;
      d_idx_r     <= '0;
      rx_valid_r  <= 1'b0;
      em_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= '0;
      best_key_r  <= '0;
      last_idx_r  <= '0;
      in_tree_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;

      rx_valid_r  <= cmd.scan_step;
      em_valid_r  <= cmd.emit_step;
      out_valid_r <= em_valid_r;

      if (cmd.scan_step || cmd.emit_step) begin
        d_idx_r <= cnt_r;
        cnt_r   <= cnt_r + 1'b1;
      end

      if (cand) begin
        found_r    <= 1'b1;
        best_r     <= d_idx_r;
        best_key_r <= newk;
      end

      if (cmd.run_init) begin
        last_idx_r <= VW'(n7 - 7'd1);
        in_tree_r  <= '0;
        found_r    <= 1'b1;
        best_r     <= '0;
        best_key_r <= '0;
      end

      // Move the best candidate into the tree, or start the report at vertex 1
      if (cmd.pick) begin
        if (found_r) begin
          pick_r            <= best_r;
          in_tree_r[best_r] <= 1'b1;
          cnt_r             <= '0;
          found_r           <= 1'b0;
        end else begin
          cnt_r <= VW'(1);
        end
      end
    end
  end

  assign stat.clr_done = (clr_cnt_r == AW'(DEPTH - 1));
  assign stat.found    = found_r;
  assign stat.cnt_last = (cnt_r == last_idx_r);

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* hdl/prim_mst_adjacency_matrix.sv */
// Prim minimum spanning tree over a stored symmetric weight matrix.
// Channels: input words on start/in_word, accepted when start is high and
// busy is low. command CMD_WRITE stores weight for the pair (row, col),
// with busy staying low, so writes can follow back to back.
// command CMD_RUN grows the tree from vertex 0 over vertex_count vertices.
// Results leave on out_valid/out_word, one word per cycle for vertices
// 1..n-1 in ascending order, each valid for exactly one cycle; the receiver
// has no way to stall them. The last word carries last = 1.
// Run with n vertices: each tree step is one pick, then one relax pass of
// n matrix reads through the single matrix read port, then a tail step.
// Each report read passes the em_valid register and then the result register
// before its result word appears.
// vertex_count is written through cfg_wr_en/cfg_wr_data. The user must write
// it only while idle; the block itself does not enforce this.
// Reset: vertex_count returns to 32 and the matrix is swept to zero, one
// cell per cycle, over all 2^(2*ceil(log2(MAX_VERTICES))) cells (1024 at the
// default size); busy stays high during the sweep.
// Depends on pmst_pkg, pmst_ctrl and pmst_dpath.
module prim_mst_adjacency_matrix #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pmst_pkg::in_word_t            in_word,
  output logic                          out_valid,
  output pmst_pkg::out_word_t           out_word,
  input  logic                          cfg_wr_en,
  input  logic [pmst_pkg::CFG_BITS-1:0] cfg_wr_data
);
  import pmst_pkg::*;

  pmst_cmd_t  cmd;
  pmst_stat_t stat;

  pmst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_word.command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  pmst_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

  // Controller issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // No result word while the matrix is being swept
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !out_valid)
    else $error("result word during clearing pass");

  // Report words come in an unbroken burst up to the last one
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last) |=> out_valid)
    else $error("gap in result burst");

  // Nothing follows the last word of a run
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last) |=> !out_valid)
    else $error("result word after last");

  // A run keeps the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_init |=> busy)
    else $error("run started without raising busy");

endmodule
